[sv/qafs_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the quote-aware field splitter.
// Depends on nothing; every other file of the block but the RAM uses it by scoped names.
package qafs_pkg;

	// Count of buffered quoted bytes; wide enough for buffer depths up to 63.
	localparam int QCNT_W = 6;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SEP_CHARS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEP_COUNT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUOTE_CHARS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QUOTE_COUNT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STRIP       = 3'd4;

	localparam logic [31:0] SEP_CHARS_RST   = 32'd44;
	localparam logic [2:0]  SEP_COUNT_RST   = 3'd1;
	localparam logic [15:0] QUOTE_CHARS_RST = 16'd34;
	localparam logic [1:0]  QUOTE_COUNT_RST = 2'd1;

	typedef struct packed {
		logic [31:0] sep_chars;
		logic [2:0]  sep_count;
		logic [15:0] quote_chars;
		logic [1:0]  quote_count;
		logic        strip;
	} cfg_t;

	// At most one command per input word: an optional leading byte, a flush of the
	// buffered quoted bytes, an optional trailing byte and an optional end mark,
	// carried out by the back end in that order.
	typedef struct packed {
		logic              pre_v;
		logic [7:0]        pre_c;
		logic [QCNT_W-1:0] flush_n;
		logic              post_v;
		logic [7:0]        post_c;
		logic              end_v;
		logic              ovf;
	} cmd_t;

	typedef struct packed {
		logic in_quote;
		logic flush_pend;
	} front_stat_t;

endpackage

[sv/quote_aware_field_splitter.sv]
`timescale 1ns / 1ps
// Top level of the quote-aware field splitter: configuration registers and
// the front end, command queue, quote buffer and back end. Uses qafs_pkg.
//
// Usage. Bytes of a string enter as words on the input queue (push/full),
// one byte per word, with string_end high on the final byte. Results leave
// on the output queue (empty/pop): each word is either a token character
// (item_kind 0) or the end mark of a nonempty token (item_kind 1), with the
// overflow flag of the current string and last_of_run marking the final
// result caused by one input word. Configuration is written through
// cfg_we/cfg_index/cfg_data while the block is idle.
//
// Timing. The back end loads each command from the queue and then emits
// its bytes, and takes no new command until the last one is done, so plain
// characters pass one command at a time. Opening a quote and buffering
// quoted bytes produce nothing. Closing a run flushes N buffered bytes at
// one per cycle while the output register is free, after a RAM read, and
// the input stays full until the flush has finished, because the flush
// reads the single buffer that new quoted bytes would write.
//
// Reset clears all quote, token and queue state and loads the default
// configuration (comma separator, double-quote, quotes stripped); the buffer
// RAM is not cleared. When the receiver stops popping, the output register
// holds its word, the command queue fills and then full rises.
module quote_aware_field_splitter #(
	parameter int QUOTE_DEPTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [7:0]                      char_in,
	input  logic                            string_end,
	output logic                            empty,
	input  logic                            pop,
	output logic                            item_kind,
	output logic [7:0]                      char_out,
	output logic                            overflow,
	output logic                            last_of_run,
	input  logic                            cfg_we,
	input  logic [qafs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [qafs_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = $clog2(QUOTE_DEPTH);

	qafs_pkg::cfg_t        cfg_q;
	qafs_pkg::cmd_t        f_cmd;
	qafs_pkg::cmd_t        q_cmd;
	qafs_pkg::front_stat_t f_stat;

	logic          cmd_push;
	logic          fifo_full;
	logic          fifo_empty;
	logic          fifo_rd;
	logic          flush_done;
	logic          buf_we;
	logic [AW-1:0] buf_waddr;
	logic [7:0]    buf_wdata;
	logic          buf_re;
	logic [AW-1:0] buf_raddr;
	logic [7:0]    buf_rdata;

	// Configuration registers; out-of-range indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sep_chars   <= qafs_pkg::SEP_CHARS_RST;
			cfg_q.sep_count   <= qafs_pkg::SEP_COUNT_RST;
			cfg_q.quote_chars <= qafs_pkg::QUOTE_CHARS_RST;
			cfg_q.quote_count <= qafs_pkg::QUOTE_COUNT_RST;
			cfg_q.strip       <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				qafs_pkg::REG_SEP_CHARS:   cfg_q.sep_chars   <= cfg_data[31:0];
				qafs_pkg::REG_SEP_COUNT:   cfg_q.sep_count   <= cfg_data[2:0];
				qafs_pkg::REG_QUOTE_CHARS: cfg_q.quote_chars <= cfg_data[15:0];
				qafs_pkg::REG_QUOTE_COUNT: cfg_q.quote_count <= cfg_data[1:0];
				qafs_pkg::REG_STRIP:       cfg_q.strip       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	qafs_front #(
		.QUOTE_DEPTH(QUOTE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.push       (push),
		.char_in    (char_in),
		.string_end (string_end),
		.full       (full),
		.fifo_full  (fifo_full),
		.cmd_push   (cmd_push),
		.cmd        (f_cmd),
		.flush_done (flush_done),
		.buf_we     (buf_we),
		.buf_waddr  (buf_waddr),
		.buf_wdata  (buf_wdata),
		.stat       (f_stat)
	);

	qafs_cmd_fifo u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_push),
		.wdata  (f_cmd),
		.full   (fifo_full),
		.rd     (fifo_rd),
		.rdata  (q_cmd),
		.empty  (fifo_empty)
	);

	qafs_ram #(
		.WIDTH(8),
		.DEPTH(QUOTE_DEPTH)
	) u_quote_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (buf_waddr),
		.wdata (buf_wdata),
		.re    (buf_re),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	qafs_back #(
		.QUOTE_DEPTH(QUOTE_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.fifo_empty  (fifo_empty),
		.fifo_rd     (fifo_rd),
		.fifo_data   (q_cmd),
		.buf_re      (buf_re),
		.buf_raddr   (buf_raddr),
		.buf_rdata   (buf_rdata),
		.flush_done  (flush_done),
		.pop         (pop),
		.empty       (empty),
		.item_kind   (item_kind),
		.char_out    (char_out),
		.overflow    (overflow),
		.last_of_run (last_of_run)
	);

	// The final word of a string always leaves the front end outside a run.
	a_end_clears_quote: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && string_end) |=> !f_stat.in_quote)
		else $error("quote run still open after end of string");

	// The back end only finishes a flush that the front end is waiting on.
	a_flush_done_pending: assert property (@(posedge clk) disable iff (!arst_n)
		flush_done |-> f_stat.flush_pend)
		else $error("flush finished with no flush outstanding");

	// While a flush is outstanding no word may be taken in.
	a_pend_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		f_stat.flush_pend |-> full)
		else $error("input open during a buffer flush");

	// A token end mark carries no character and closes its run of results.
	a_end_mark_form: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && item_kind) |-> (char_out == 8'd0 && last_of_run))
		else $error("malformed token end mark");

endmodule

[sv/qafs_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered, enabled read port.
// Depends on nothing.
module qafs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/qafs_cmd_fifo.sv]
`timescale 1ns / 1ps
// Two-entry command queue between the front end and the back end.
// Depends on qafs_pkg for the command type.
module qafs_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  qafs_pkg::cmd_t wdata,
	output logic          full,
	input  logic          rd,
	output qafs_pkg::cmd_t rdata,
	output logic          empty
);

	qafs_pkg::cmd_t slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) begin
			slot_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr && !full) begin
				wp_q <= !wp_q;
			end
			if (rd && !empty) begin
				rp_q <= !rp_q;
			end
			unique case ({wr && !full, rd && !empty})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[sv/qafs_front.sv]
`timescale 1ns / 1ps
// Front end: accepts input words, classifies each byte, keeps the quote and
// token state, writes quoted bytes to the buffer and issues commands.
// Depends on qafs_pkg.
module qafs_front #(
	parameter int QUOTE_DEPTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  qafs_pkg::cfg_t                 cfg,
	input  logic                           push,
	input  logic [7:0]                     char_in,
	input  logic                           string_end,
	output logic                           full,
	input  logic                           fifo_full,
	output logic                           cmd_push,
	output qafs_pkg::cmd_t                 cmd,
	input  logic                           flush_done,
	output logic                           buf_we,
	output logic [$clog2(QUOTE_DEPTH)-1:0] buf_waddr,
	output logic [7:0]                     buf_wdata,
	output qafs_pkg::front_stat_t          stat
);

	localparam int AW = $clog2(QUOTE_DEPTH);
	localparam logic [qafs_pkg::QCNT_W-1:0] DEPTH_C = qafs_pkg::QCNT_W'(QUOTE_DEPTH);

	logic                        in_quote_q;
	logic [7:0]                  open_q;
	logic [qafs_pkg::QCNT_W-1:0] cnt_q;
	logic                        has_q;
	logic                        ovf_q;
	logic                        pend_q;

	logic                        acc;
	logic                        is_sep;
	logic                        is_quote;
	logic                        sep_path;
	logic                        mid_has;
	logic                        iq_n;
	logic [7:0]                  open_n;
	logic [qafs_pkg::QCNT_W-1:0] cnt_n;
	logic                        has_n;
	logic                        ovf_n;
	qafs_pkg::cmd_t              cmd_n;

	// A flush in flight reads the buffer, so no new word enters until it ends.
	assign full = fifo_full || pend_q;
	assign acc  = push && !full;

	always_comb begin
		is_sep   = 1'b0;
		is_quote = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if ((3'(i) < cfg.sep_count) && (cfg.sep_chars[8*i +: 8] == char_in)) begin
				is_sep = 1'b1;
			end
		end
		for (int i = 0; i < 2; i++) begin
			if ((2'(i) < cfg.quote_count) && (cfg.quote_chars[8*i +: 8] == char_in)) begin
				is_quote = 1'b1;
			end
		end
	end

	always_comb begin
		cmd_n    = '0;
		iq_n     = in_quote_q;
		open_n   = open_q;
		cnt_n    = cnt_q;
		ovf_n    = ovf_q;
		sep_path = 1'b0;
		buf_we   = 1'b0;
		if (in_quote_q) begin
			if (char_in == open_q) begin
				cmd_n.pre_v   = !cfg.strip;
				cmd_n.pre_c   = open_q;
				cmd_n.flush_n = cnt_q;
				cmd_n.post_v  = !cfg.strip;
				cmd_n.post_c  = char_in;
				iq_n          = 1'b0;
				open_n        = 8'd0;
				cnt_n         = '0;
			end else if (cnt_q < DEPTH_C) begin
				buf_we = acc;
				cnt_n  = cnt_q + qafs_pkg::QCNT_W'(1);
			end else begin
				ovf_n = 1'b1;
			end
		end else if (is_quote) begin
			// A byte in both sets opens a run.
			iq_n   = 1'b1;
			open_n = char_in;
			cnt_n  = '0;
		end else if (is_sep) begin
			sep_path    = 1'b1;
			cmd_n.end_v = has_q;
		end else begin
			cmd_n.pre_v = 1'b1;
			cmd_n.pre_c = char_in;
		end

		// An open run at the end of the string gives up its opening quote and
		// its buffered text joins the final token.
		if (string_end && iq_n) begin
			cmd_n.flush_n = cnt_n;
		end

		mid_has = !sep_path && (has_q || cmd_n.pre_v || cmd_n.post_v ||
			(cmd_n.flush_n != '0));
		if (string_end && mid_has) begin
			cmd_n.end_v = 1'b1;
		end
		cmd_n.ovf = ovf_n;
		has_n     = mid_has;

		if (string_end) begin
			iq_n   = 1'b0;
			open_n = 8'd0;
			cnt_n  = '0;
			has_n  = 1'b0;
			ovf_n  = 1'b0;
		end
	end

	assign cmd       = cmd_n;
	assign cmd_push  = acc && (cmd_n.pre_v || cmd_n.post_v || cmd_n.end_v ||
		(cmd_n.flush_n != '0));
	assign buf_waddr = cnt_q[AW-1:0];
	assign buf_wdata = char_in;

	assign stat.in_quote   = in_quote_q;
	assign stat.flush_pend = pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_quote_q <= 1'b0;
			open_q     <= 8'd0;
			cnt_q      <= '0;
			has_q      <= 1'b0;
			ovf_q      <= 1'b0;
			pend_q     <= 1'b0;
		end else begin
			if (acc) begin
				in_quote_q <= iq_n;
				open_q     <= open_n;
				cnt_q      <= cnt_n;
				has_q      <= has_n;
				ovf_q      <= ovf_n;
			end
			if (cmd_push && (cmd_n.flush_n != '0)) begin
				pend_q <= 1'b1;
			end else if (flush_done) begin
				pend_q <= 1'b0;
			end
		end
	end

endmodule

[sv/qafs_back.sv]
`timescale 1ns / 1ps
// Back end: carries out queued commands and produces result words into the
// output register, reading buffered quoted bytes from the RAM.
// Depends on qafs_pkg.
module qafs_back #(
	parameter int QUOTE_DEPTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           fifo_empty,
	output logic                           fifo_rd,
	input  qafs_pkg::cmd_t                 fifo_data,
	output logic                           buf_re,
	output logic [$clog2(QUOTE_DEPTH)-1:0] buf_raddr,
	input  logic [7:0]                     buf_rdata,
	output logic                           flush_done,
	input  logic                           pop,
	output logic                           empty,
	output logic                           item_kind,
	output logic [7:0]                     char_out,
	output logic                           overflow,
	output logic                           last_of_run
);

	localparam int AW = $clog2(QUOTE_DEPTH);

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_PRE   = 3'd1;
	localparam logic [2:0] PH_FRD   = 3'd2;
	localparam logic [2:0] PH_FLUSH = 3'd3;
	localparam logic [2:0] PH_POST  = 3'd4;
	localparam logic [2:0] PH_END   = 3'd5;

	function automatic logic [2:0] from_post(qafs_pkg::cmd_t c);
		return c.end_v ? PH_END : PH_IDLE;
	endfunction

	function automatic logic [2:0] from_flush(qafs_pkg::cmd_t c);
		return c.post_v ? PH_POST : from_post(c);
	endfunction

	function automatic logic [2:0] from_pre(qafs_pkg::cmd_t c);
		return (c.flush_n != '0) ? PH_FRD : from_flush(c);
	endfunction

	function automatic logic [2:0] first_phase(qafs_pkg::cmd_t c);
		return c.pre_v ? PH_PRE : from_pre(c);
	endfunction

	logic [2:0]                  ph_q;
	logic [2:0]                  ph_n;
	logic [qafs_pkg::QCNT_W-1:0] idx_q;
	logic [qafs_pkg::QCNT_W-1:0] idx_n;
	qafs_pkg::cmd_t              cmd_q;

	logic       out_v_q;
	logic       kind_q;
	logic [7:0] char_q;
	logic       ovf_q;
	logic       last_q;

	logic       out_free;
	logic       emit;
	logic       e_kind;
	logic [7:0] e_char;
	logic       e_last;

	assign out_free = !out_v_q || pop;
	assign fifo_rd  = (ph_q == PH_IDLE) && !fifo_empty;

	always_comb begin
		ph_n       = ph_q;
		idx_n      = idx_q;
		emit       = 1'b0;
		e_kind     = 1'b0;
		e_char     = 8'd0;
		e_last     = 1'b0;
		buf_re     = 1'b0;
		flush_done = 1'b0;
		unique case (ph_q)
			PH_IDLE: begin
				if (!fifo_empty) begin
					ph_n  = first_phase(fifo_data);
					idx_n = '0;
				end
			end
			PH_PRE: begin
				if (out_free) begin
					emit   = 1'b1;
					e_char = cmd_q.pre_c;
					ph_n   = from_pre(cmd_q);
					e_last = (ph_n == PH_IDLE);
				end
			end
			PH_FRD: begin
				buf_re = 1'b1;
				idx_n  = '0;
				ph_n   = PH_FLUSH;
			end
			PH_FLUSH: begin
				if (out_free) begin
					emit   = 1'b1;
					e_char = buf_rdata;
					if (idx_q == (cmd_q.flush_n - qafs_pkg::QCNT_W'(1))) begin
						flush_done = 1'b1;
						ph_n       = from_flush(cmd_q);
						e_last     = (ph_n == PH_IDLE);
					end else begin
						buf_re = 1'b1;
						idx_n  = idx_q + qafs_pkg::QCNT_W'(1);
					end
				end
			end
			PH_POST: begin
				if (out_free) begin
					emit   = 1'b1;
					e_char = cmd_q.post_c;
					ph_n   = from_post(cmd_q);
					e_last = !cmd_q.end_v;
				end
			end
			PH_END: begin
				if (out_free) begin
					emit   = 1'b1;
					e_kind = 1'b1;
					e_last = 1'b1;
					ph_n   = PH_IDLE;
				end
			end
			default: ph_n = PH_IDLE;
		endcase
	end

	assign buf_raddr = idx_n[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_IDLE;
			idx_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			ph_q  <= ph_n;
			idx_q <= idx_n;
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fifo_rd) begin
			cmd_q <= fifo_data;
		end
		if (emit) begin
			kind_q <= e_kind;
			char_q <= e_char;
			ovf_q  <= cmd_q.ovf;
			last_q <= e_last;
		end
	end

	assign empty       = !out_v_q;
	assign item_kind   = kind_q;
	assign char_out    = char_q;
	assign overflow    = ovf_q;
	assign last_of_run = last_q;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for quote_aware_field_splitter: a directed table, then
// random strings under three idling profiles, checked against a local predictor.
// Depends on qafs_pkg and the splitter RTL only.
module tb;

	// Quote buffer depth given to the block and assumed by the predictor.
	localparam int BUF_DEPTH = 32;
	// Cycles allowed after the last expected word before the block counts as idle.
	// Words that open or fill a quoted run give no result but still have to pass
	// through the front end.
	localparam int SETTLE_CYCLES = 16;

	typedef enum logic {
		KIND_CHAR = 1'b0,
		KIND_END  = 1'b1
	} item_kind_e;

	// How a row of the directed table is checked: by the predictor, or by a
	// result typed straight into the row (none, the input character, an end mark).
	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_NONE,
		CHK_CHAR,
		CHK_END
	} row_check_e;

	typedef enum logic {
		ROW_WORD,
		ROW_REG
	} row_op_e;

	typedef struct packed {
		row_op_e                         op;
		logic [qafs_pkg::CFG_IDX_W-1:0]  idx;
		logic [qafs_pkg::CFG_DATA_W-1:0] data;
		logic [7:0]                      ch;
		logic                            fin;
		row_check_e                      chk;
	} stim_row_t;

	typedef struct packed {
		item_kind_e kind;
		logic [7:0] ch;
		logic       ovf;
		logic       last;
	} token_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [7:0] char_in = 8'h00;
	logic string_end = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic item_kind;
	logic [7:0] char_out;
	logic overflow;
	logic last_of_run;
	logic cfg_we = 1'b0;
	logic [qafs_pkg::CFG_IDX_W-1:0] cfg_index = qafs_pkg::REG_SEP_CHARS;
	logic [qafs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// Travels with each input word so that the checker knows how to treat it.
	row_check_e row_chk = CHK_MODEL;

	int send_gap_pct = 0;
	int pop_stall_pct = 0;
	int mismatches = 0;

	// Configuration as the block should hold it.
	logic [31:0] sep_set = qafs_pkg::SEP_CHARS_RST;
	logic [2:0]  sep_n = qafs_pkg::SEP_COUNT_RST;
	logic [15:0] quote_set = qafs_pkg::QUOTE_CHARS_RST;
	logic [1:0]  quote_n = qafs_pkg::QUOTE_COUNT_RST;
	logic        strip_marks = 1'b1;

	// Parser state of the predictor.
	logic       in_run = 1'b0;
	logic [7:0] run_quote = 8'h00;
	logic [7:0] qbuf [BUF_DEPTH];
	int         run_len = 0;
	logic       token_open = 1'b0;
	logic       ovf_seen = 1'b0;

	// Words caused by the input word being predicted, then the store of words
	// still owed by the block, oldest first.
	token_word_t run_words[$];
	token_word_t expected_words[$];

	stim_row_t dir_rows[$];

	quote_aware_field_splitter #(
		.QUOTE_DEPTH(BUF_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.char_in(char_in),
		.string_end(string_end),
		.empty(empty),
		.pop(pop),
		.item_kind(item_kind),
		.char_out(char_out),
		.overflow(overflow),
		.last_of_run(last_of_run),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("tb: FAIL");
		$finish;
	end

	function automatic token_word_t make_word(input item_kind_e k, input logic [7:0] ch,
			input logic ovf, input logic last);
		token_word_t w;
		w.kind = k;
		w.ch = (k == KIND_CHAR) ? ch : 8'h00;
		w.ovf = ovf;
		w.last = last;
		return w;
	endfunction

	function automatic void add_run_word(input token_word_t w);
		run_words.insert(run_words.size(), w);
	endfunction

	function automatic void add_expected(input token_word_t w);
		expected_words.insert(expected_words.size(), w);
	endfunction

	function automatic void add_row(input stim_row_t r);
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	// Counts above the number of packed bytes behave as the full set.
	function automatic logic is_sep(input logic [7:0] c);
		int n;
		n = (sep_n > 3'd4) ? 4 : int'(sep_n);
		for (int i = 0; i < n; i++)
			if (sep_set[8*i +: 8] == c)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic is_quote(input logic [7:0] c);
		int n;
		n = (quote_n > 2'd2) ? 2 : int'(quote_n);
		for (int i = 0; i < n; i++)
			if (quote_set[8*i +: 8] == c)
				return 1'b1;
		return 1'b0;
	endfunction

	// Any character word marks the current token as nonempty.
	function automatic void emit(input item_kind_e k, input logic [7:0] ch);
		add_run_word(make_word(k, ch, ovf_seen, 1'b0));
		if (k == KIND_CHAR)
			token_open = 1'b1;
	endfunction

	function automatic void flush_run();
		for (int i = 0; i < run_len; i++)
			emit(KIND_CHAR, qbuf[i]);
		run_len = 0;
	endfunction

	function automatic void close_token();
		if (token_open)
			emit(KIND_END, 8'h00);
		token_open = 1'b0;
	endfunction

	// Works out the words that one accepted input word causes, into run_words.
	// Quote membership is tested before separators, so a byte in both sets opens
	// a run. Inside a run only the opening byte closes it.
	function automatic void split_word(input logic [7:0] c, input logic fin);
		run_words.delete();
		if (in_run) begin
			if (c == run_quote) begin
				if (!strip_marks)
					emit(KIND_CHAR, run_quote);
				flush_run();
				if (!strip_marks)
					emit(KIND_CHAR, c);
				in_run = 1'b0;
				run_quote = 8'h00;
			end else if (run_len < BUF_DEPTH) begin
				qbuf[run_len] = c;
				run_len++;
			end else begin
				ovf_seen = 1'b1;
			end
		end else if (is_quote(c)) begin
			in_run = 1'b1;
			run_quote = c;
			run_len = 0;
		end else if (is_sep(c)) begin
			close_token();
		end else begin
			emit(KIND_CHAR, c);
		end

		// An open run at the end of the string loses its opening quote whatever
		// the strip setting, and its text joins the final token.
		if (fin) begin
			if (in_run)
				flush_run();
			close_token();
			in_run = 1'b0;
			run_quote = 8'h00;
			run_len = 0;
			token_open = 1'b0;
			ovf_seen = 1'b0;
		end

		if (run_words.size() > 0)
			run_words[run_words.size() - 1].last = 1'b1;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 100)
			$display("tb: mismatch at %0t ns: %s", $time, what);
	endtask

	// Everything happens on values sampled just before the edge: register
	// writes update the configuration copy, accepted input words are predicted
	// and accepted result words are checked against the oldest expectation.
	always @(posedge clk) begin
		token_word_t w;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					qafs_pkg::REG_SEP_CHARS:   sep_set = cfg_data;
					qafs_pkg::REG_SEP_COUNT:   sep_n = cfg_data[2:0];
					qafs_pkg::REG_QUOTE_CHARS: quote_set = cfg_data[15:0];
					qafs_pkg::REG_QUOTE_COUNT: quote_n = cfg_data[1:0];
					qafs_pkg::REG_STRIP:       strip_marks = cfg_data[0];
					default: ;
				endcase
			end

			if (push && !full) begin
				split_word(char_in, string_end);
				case (row_chk)
					CHK_MODEL: begin
						foreach (run_words[i])
							add_expected(run_words[i]);
					end
					CHK_CHAR: add_expected(make_word(KIND_CHAR, char_in, 1'b0, 1'b1));
					CHK_END:  add_expected(make_word(KIND_END, 8'h00, 1'b0, 1'b1));
					default: ;
				endcase
			end

			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("unexpected word kind %0d char %02h",
						item_kind, char_out));
				end else begin
					w = expected_words.pop_front();
					if (item_kind !== w.kind)
						report_mismatch($sformatf("item_kind %0d, expected %0d", item_kind, w.kind));
					if (char_out !== w.ch)
						report_mismatch($sformatf("char_out %02h, expected %02h", char_out, w.ch));
					if (overflow !== w.ovf)
						report_mismatch($sformatf("overflow %0d, expected %0d", overflow, w.ovf));
					if (last_of_run !== w.last)
						report_mismatch($sformatf("last_of_run %0d, expected %0d",
							last_of_run, w.last));
				end
			end
		end
	end

	// The receiver stalls on its own schedule, independent of empty.
	always @(posedge clk) begin
		pop <= arst_n && ($urandom_range(99) >= pop_stall_pct);
	end

	function automatic stim_row_t word_row(input logic [7:0] ch, input logic fin,
			input row_check_e chk);
		stim_row_t r;
		r = '0;
		r.op = ROW_WORD;
		r.ch = ch;
		r.fin = fin;
		r.chk = chk;
		return r;
	endfunction

	function automatic stim_row_t reg_row(input logic [qafs_pkg::CFG_IDX_W-1:0] idx,
			input logic [qafs_pkg::CFG_DATA_W-1:0] data);
		stim_row_t r;
		r = '0;
		r.op = ROW_REG;
		r.idx = idx;
		r.data = data;
		r.chk = CHK_NONE;
		return r;
	endfunction

	// Offers one word after a random gap and returns at the edge that takes it.
	task automatic send_word(input logic [7:0] ch, input logic fin, input row_check_e chk);
		while ($urandom_range(99) < send_gap_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		char_in <= ch;
		string_end <= fin;
		row_chk <= chk;
		do
			@(posedge clk);
		while (full);
	endtask

	// Holds the sender back until every owed word has come out, then lets the
	// front end settle so that the block is idle. The first edge makes sure the
	// checker has taken in the word accepted just before.
	task automatic drain_results();
		push <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [qafs_pkg::CFG_IDX_W-1:0] idx,
			input logic [qafs_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] sep_byte();
		int n;
		n = (sep_n > 3'd4) ? 4 : int'(sep_n);
		if (n == 0)
			return 8'($urandom_range(255));
		return sep_set[8*$urandom_range(n - 1) +: 8];
	endfunction

	function automatic logic [7:0] quote_byte();
		int n;
		n = (quote_n > 2'd2) ? 2 : int'(quote_n);
		if (n == 0)
			return 8'($urandom_range(255));
		return quote_set[8*$urandom_range(n - 1) +: 8];
	endfunction

	// Letters and raw bytes in equal share, with the configured special bytes mixed in.
	function automatic logic [7:0] pick_char();
		case ($urandom_range(9))
			0, 1, 2, 3: return 8'h61 + 8'($urandom_range(25));
			4:          return sep_byte();
			5:          return quote_byte();
			default:    return 8'($urandom_range(255));
		endcase
	endfunction

	// Text for a quoted run that must not close it early.
	function automatic logic [7:0] run_byte(input logic [7:0] q);
		logic [7:0] c;
		do
			c = pick_char();
		while (c == q);
		return c;
	endfunction

	// Builds one string from plain text, separators and quoted runs, with some
	// unclosed runs and some pure noise, then sends it with the end flag on its
	// final byte. A nonzero long_len gives one short segment and then a run of
	// long_len bytes; that run is closed only half of the time.
	task automatic send_string(input int long_len, inout int sent);
		logic [7:0] text[$];
		logic [7:0] q;
		int segs;
		segs = (long_len > 0) ? 1 : $urandom_range(1, 5);
		for (int s = 0; s < segs; s++) begin
			case ($urandom_range(9))
				0, 1, 2, 3: repeat ($urandom_range(1, 5)) text.insert(text.size(), pick_char());
				4, 5:       repeat ($urandom_range(1, 2)) text.insert(text.size(), sep_byte());
				6, 7, 8: begin
					q = quote_byte();
					text.insert(text.size(), q);
					repeat ($urandom_range(0, 6)) text.insert(text.size(), run_byte(q));
					text.insert(text.size(), q);
				end
				default: begin
					q = quote_byte();
					text.insert(text.size(), q);
					repeat ($urandom_range(0, 4)) text.insert(text.size(), pick_char());
				end
			endcase
		end
		if (long_len > 0) begin
			q = quote_byte();
			text.insert(text.size(), q);
			repeat (long_len) text.insert(text.size(), run_byte(q));
			if ($urandom_range(1))
				text.insert(text.size(), q);
		end else if ($urandom_range(9) == 0) begin
			text.delete();
			repeat ($urandom_range(1, 8)) text.insert(text.size(), 8'($urandom_range(255)));
		end
		foreach (text[i]) begin
			// Now and then the sender waits for the output side to run dry.
			if ($urandom_range(99) < 3)
				drain_results();
			send_word(text[i], i == text.size() - 1, CHK_MODEL);
			sent++;
		end
	endtask

	initial begin
		stim_row_t row;
		logic [31:0] sep_v;
		logic [2:0]  sep_c;
		logic [15:0] quote_v;
		logic [1:0]  quote_c;
		logic        strip_v;
		int sent;
		int long_len;

		// Reset configuration: comma separates, double quote opens runs, marks
		// are stripped. A separator on an empty token gives nothing.
		add_row(word_row(8'h2C, 1'b0, CHK_NONE));
		add_row(word_row(8'h00, 1'b0, CHK_CHAR));
		add_row(word_row(8'hFF, 1'b0, CHK_CHAR));
		add_row(word_row(8'h2C, 1'b0, CHK_END));
		// A quoted run keeps separators and other quotes as text, and the text
		// after it carries on in the same token.
		add_row(word_row(8'h22, 1'b0, CHK_NONE));
		add_row(word_row(8'h2C, 1'b0, CHK_NONE));
		add_row(word_row(8'h27, 1'b0, CHK_NONE));
		add_row(word_row(8'h22, 1'b0, CHK_MODEL));
		add_row(word_row(8'h78, 1'b0, CHK_CHAR));
		add_row(word_row(8'h2C, 1'b1, CHK_MODEL));
		// A run still open at the end of the string.
		add_row(word_row(8'h22, 1'b0, CHK_NONE));
		add_row(word_row(8'h71, 1'b1, CHK_MODEL));
		// A string that is one separator long.
		add_row(word_row(8'h2C, 1'b1, CHK_NONE));

		// Marks kept, apostrophe and comma as quotes (comma is in both sets) and
		// a quote count above its maximum.
		add_row(reg_row(qafs_pkg::REG_STRIP, 32'd0));
		add_row(reg_row(qafs_pkg::REG_QUOTE_CHARS, 32'h0000_2C27));
		add_row(reg_row(qafs_pkg::REG_QUOTE_COUNT, 32'd3));
		add_row(word_row(8'h2C, 1'b0, CHK_NONE));
		add_row(word_row(8'h22, 1'b0, CHK_NONE));
		add_row(word_row(8'h27, 1'b0, CHK_NONE));
		add_row(word_row(8'h2C, 1'b0, CHK_MODEL));
		// With marks kept, an open run at the end still loses its opening quote.
		add_row(word_row(8'h27, 1'b0, CHK_NONE));
		add_row(word_row(8'h7A, 1'b1, CHK_MODEL));

		// Four separators including both byte extremes, a separator count above
		// its maximum, and no quotes at all.
		add_row(reg_row(qafs_pkg::REG_SEP_CHARS, 32'hFF00_3B7C));
		add_row(reg_row(qafs_pkg::REG_SEP_COUNT, 32'd7));
		add_row(reg_row(qafs_pkg::REG_QUOTE_COUNT, 32'd0));
		add_row(word_row(8'h61, 1'b0, CHK_CHAR));
		add_row(word_row(8'hFF, 1'b0, CHK_END));
		add_row(word_row(8'h00, 1'b0, CHK_NONE));
		add_row(word_row(8'h2C, 1'b0, CHK_CHAR));
		add_row(word_row(8'h27, 1'b1, CHK_MODEL));

		// No separators: every byte is token text.
		add_row(reg_row(qafs_pkg::REG_SEP_COUNT, 32'd0));
		add_row(reg_row(qafs_pkg::REG_SEP_CHARS, 32'd0));
		add_row(word_row(8'h00, 1'b0, CHK_CHAR));
		add_row(word_row(8'hFF, 1'b1, CHK_MODEL));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_gap_pct = 11;
		pop_stall_pct = 69;
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.op == ROW_REG) begin
				drain_results();
				write_reg(row.idx, row.data);
			end else begin
				send_word(row.ch, row.fin, row.chk);
			end
		end

		// Three random phases, each with its own configuration and idling mix.
		// The first two open with a long quoted run: in the first it is longer than
		// the buffer, in the second it lands around the exact limit.
		for (int phase = 0; phase < 3; phase++) begin
			drain_results();
			case (phase)
				0: begin
					sep_v = $urandom;
					sep_c = 3'd4;
					quote_v = 16'($urandom_range(65535));
					quote_c = 2'd2;
					strip_v = 1'b1;
					long_len = $urandom_range(BUF_DEPTH + 1, BUF_DEPTH + 8);
					send_gap_pct = 11;
					pop_stall_pct = 69;
				end
				1: begin
					sep_v = 32'hFFFF_FFFF;
					sep_c = 3'd5;
					quote_v = 16'hFF00;
					quote_c = 2'd1;
					strip_v = 1'b0;
					long_len = $urandom_range(BUF_DEPTH - 4, BUF_DEPTH + 4);
					send_gap_pct = 69;
					pop_stall_pct = 11;
				end
				default: begin
					sep_v = $urandom;
					sep_c = 3'($urandom_range(7));
					quote_v = 16'($urandom_range(65535));
					quote_c = 2'($urandom_range(3));
					strip_v = 1'($urandom_range(1));
					long_len = 0;
					send_gap_pct = 0;
					pop_stall_pct = 0;
				end
			endcase
			write_reg(qafs_pkg::REG_SEP_CHARS, sep_v);
			write_reg(qafs_pkg::REG_SEP_COUNT, 32'(sep_c));
			write_reg(qafs_pkg::REG_QUOTE_CHARS, 32'(quote_v));
			write_reg(qafs_pkg::REG_QUOTE_COUNT, 32'(quote_c));
			write_reg(qafs_pkg::REG_STRIP, 32'(strip_v));

			sent = 0;
			send_string(long_len, sent);
			while (sent < 20)
				send_string(0, sent);
		end

		drain_results();
		if (mismatches == 0 && expected_words.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
